// ===== hdl/r2p_pkg.sv =====
`default_nettype none
package r2p_pkg;

   // Angle pipeline
   localparam int CORDIC_STEPS = 56;
   localparam int FINE_BITS = 64;

   // pi * 2^60 is the first arctangent entry (pi/4 scaled by 2^62)
   localparam logic [FINE_BITS-1:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

   // 2^64 / pi rounded to nearest, split for the partial products
   localparam logic [31:0] INV_PI_HI = 32'h517C_C1B7;
   localparam logic [31:0] INV_PI_LO = 32'h2722_0A95;

   // Fine binary angle: a full turn is 2^63
   localparam logic [FINE_BITS-1:0] TURN_EIGHTH = 64'h1000_0000_0000_0000;
   localparam logic [FINE_BITS-1:0] TURN_QUARTER = 64'h2000_0000_0000_0000;
   localparam logic [FINE_BITS-1:0] TURN_HALF = 64'h4000_0000_0000_0000;

   localparam logic [15:0] MAG_MAX = 16'hFFFF;

   typedef struct packed {
      logic rneg;   // real part negative
      logic ineg;   // imaginary part negative
      logic swap;   // |im| > |re|, octant mirrored about the diagonal
      logic axis;   // one of the parts is zero
      logic diag;   // |re| == |im|
   } flags_type;

   // Shift-subtract quotient, evaluated only for elaboration constants
   function automatic logic [FINE_BITS-1:0] div_small(input logic [FINE_BITS-1:0] num,
                                                      input logic [FINE_BITS-1:0] den);
      logic [FINE_BITS-1:0] quo;
      logic [FINE_BITS-1:0] rmd;
      quo = '0;
      rmd = '0;
      for (int b = FINE_BITS - 1; b >= 0; b--) begin
         rmd = {rmd[FINE_BITS-2:0], num[b]};
         if (rmd >= den) begin
            rmd = rmd - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-step) * 2^62 from the truncated series
   function automatic logic [FINE_BITS-1:0] atan_entry(input int step);
      logic [FINE_BITS-1:0] sum;
      logic [FINE_BITS-1:0] term;
      int e;
      sum = '0;
      if (step == 0) begin
         sum = PI_Q60;
      end else begin
         for (int k = 0; k < 32; k++) begin
            e = step * (2 * k + 1);
            if (e <= 62) begin
               term = div_small(64'd1 << (62 - e), 64'(2 * k + 1));
               if ((k & 1) == 0) begin
                  sum = sum + term;
               end else begin
                  sum = sum - term;
               end
            end
         end
      end
      return sum;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/r2p_front.sv =====
`default_nettype none
module r2p_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic                        up_valid,
   input  wire logic signed [SAMPLE_BITS-1:0] up_real,
   input  wire logic signed [SAMPLE_BITS-1:0] up_imag,
   output logic                             dn_valid,
   output r2p_pkg::flags_type               dn_flags,
   output logic [63:0]                      dn_x,
   output logic [63:0]                      dn_y,
   output logic [2*SAMPLE_BITS-1:0]         dn_sq
);
   localparam int W = SAMPLE_BITS;
   localparam int CORDIC_SHIFT = 56 - W;

   logic [2:0] vld_ff;

   // stage 1: absolute values
   logic [W-1:0] re_bits, im_bits;
   logic [W-1:0] ax_in, ay_in, ax_ff, ay_ff;
   logic         rneg_ff, ineg_ff;

   // stage 2: squares and octant fold
   logic [2*W-1:0]       sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [W-1:0]         u_in, v_in, u_ff, v_ff;
   r2p_pkg::flags_type   flags_in, flags2_ff, flags3_ff;

   // stage 3: sum of squares and scaled CORDIC start
   logic [2*W-1:0] sq_in, sq_ff;
   logic [63:0]    x_in, y_in, x_ff, y_ff;

   assign re_bits = $unsigned(up_real);
   assign im_bits = $unsigned(up_imag);
   assign ax_in = re_bits[W-1] ? ({W{1'b0}} - re_bits) : re_bits;
   assign ay_in = im_bits[W-1] ? ({W{1'b0}} - im_bits) : im_bits;

   assign sqx_in = {{W{1'b0}}, ax_ff} * {{W{1'b0}}, ax_ff};
   assign sqy_in = {{W{1'b0}}, ay_ff} * {{W{1'b0}}, ay_ff};

   always_comb begin
      flags_in.rneg = rneg_ff;
      flags_in.ineg = ineg_ff;
      flags_in.swap = ay_ff > ax_ff;
      flags_in.axis = (ax_ff == '0) || (ay_ff == '0);
      flags_in.diag = ax_ff == ay_ff;
      u_in = flags_in.swap ? ay_ff : ax_ff;
      v_in = flags_in.swap ? ax_ff : ay_ff;
   end

   assign sq_in = sqx_ff + sqy_ff;
   assign x_in = {{(64-W){1'b0}}, u_ff} << CORDIC_SHIFT;
   assign y_in = {{(64-W){1'b0}}, v_ff} << CORDIC_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         rneg_ff <= re_bits[W-1];
         ineg_ff <= im_bits[W-1];
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         u_ff <= u_in;
         v_ff <= v_in;
         flags2_ff <= flags_in;
         sq_ff <= sq_in;
         x_ff <= x_in;
         y_ff <= y_in;
         flags3_ff <= flags2_ff;
      end
   end

   assign dn_valid = vld_ff[2];
   assign dn_flags = flags3_ff;
   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_sq = sq_ff;
endmodule
`default_nettype wire

// ===== hdl/r2p_cell.sv =====
`default_nettype none
module r2p_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int STEP = 0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      up_valid,
   input  wire r2p_pkg::flags_type        up_flags,
   input  wire logic [63:0]               up_x,
   input  wire logic [63:0]               up_y,
   input  wire logic [63:0]               up_z,
   input  wire logic [2*SAMPLE_BITS-1:0]  up_sq,
   input  wire logic [SAMPLE_BITS-1:0]    up_root,
   input  wire logic [SAMPLE_BITS+1:0]    up_rem,
   output logic                           dn_valid,
   output r2p_pkg::flags_type             dn_flags,
   output logic [63:0]                    dn_x,
   output logic [63:0]                    dn_y,
   output logic [63:0]                    dn_z,
   output logic [2*SAMPLE_BITS-1:0]       dn_sq,
   output logic [SAMPLE_BITS-1:0]         dn_root,
   output logic [SAMPLE_BITS+1:0]         dn_rem
);
   localparam int W = SAMPLE_BITS;
   localparam logic [63:0] ATAN_STEP = r2p_pkg::atan_entry(STEP);

   logic                 valid_ff;
   r2p_pkg::flags_type   flags_ff;
   logic [63:0]          x_shift, y_shift;
   logic [63:0]          x_in, y_in, z_in, x_ff, y_ff, z_ff;
   logic [2*W-1:0]       sq_in, sq_ff;
   logic [W-1:0]         root_in, root_ff;
   logic [W+1:0]         rem_in, rem_ff;

   // one CORDIC vectoring rotation
   assign x_shift = up_x >> STEP;
   assign y_shift = $unsigned($signed(up_y) >>> STEP);

   always_comb begin
      if (up_y[63]) begin
         x_in = up_x - y_shift;
         y_in = up_y + x_shift;
         z_in = up_z - ATAN_STEP;
      end else begin
         x_in = up_x + y_shift;
         y_in = up_y - x_shift;
         z_in = up_z + ATAN_STEP;
      end
   end

   // one root digit: bring down the next two bits of the sum of squares
   assign sq_in = {up_sq[2*W-3:0], 2'b00};

   generate
      if (STEP < W) begin : g_root
         logic [W+3:0] rem_shift, trial, rem_diff;
         assign rem_shift = {up_rem, up_sq[2*W-1 -: 2]};
         assign trial = {2'b00, up_root, 2'b01};
         assign rem_diff = rem_shift - trial;
         always_comb begin
            if (rem_shift >= trial) begin
               rem_in = rem_diff[W+1:0];
               root_in = {up_root[W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[W+1:0];
               root_in = {up_root[W-2:0], 1'b0};
            end
         end
      end else begin : g_hold
         assign rem_in = up_rem;
         assign root_in = up_root;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff <= up_flags;
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         sq_ff <= sq_in;
         root_ff <= root_in;
         rem_ff <= rem_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_flags = flags_ff;
   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_z = z_ff;
   assign dn_sq = sq_ff;
   assign dn_root = root_ff;
   assign dn_rem = rem_ff;
endmodule
`default_nettype wire

// ===== hdl/r2p_back.sv =====
`default_nettype none
module r2p_back #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     up_valid,
   input  wire r2p_pkg::flags_type       up_flags,
   input  wire logic [63:0]              up_z,
   input  wire logic [SAMPLE_BITS-1:0]   up_root,
   input  wire logic [SAMPLE_BITS+1:0]   up_rem,
   output logic                          dn_valid,
   output logic [15:0]                   dn_magnitude,
   output logic [15:0]                   dn_phase
);
   localparam int W = SAMPLE_BITS;
   localparam int MAGW = W + 1;
   localparam int EW = (MAGW > 16) ? MAGW : 17;

   logic [8:0] vld_ff;

   r2p_pkg::flags_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff, f7_ff;

   // magnitude: round, then saturate
   logic [W:0]      root_ext;
   logic [MAGW-1:0] mag1_in, mag1_ff;
   logic [EW-1:0]   mag_wide;
   logic [15:0]     mag2_in;
   logic [15:0]     mag2_ff, mag3_ff, mag4_ff, mag5_ff, mag6_ff, mag7_ff, mag8_ff, mag9_ff;

   // angle times 1/pi as four partial products
   logic [63:0]  z1_ff, z2_ff, z3_ff;
   logic [63:0]  p1_in, p2_in, p3_in, p4_in;
   logic [63:0]  p1_ff, p2_ff, p3_ff, p4_ff;
   logic [127:0] acc3_in, acc4_in, acc5_in;
   logic [127:0] acc2_ff, acc3_ff, acc4_ff;
   logic [63:0]  fine5_ff;

   // octant unfold and rounding
   logic [63:0]  base6, fine6_in, fine6_ff;
   logic [63:0]  fine7_in, fine7_ff;
   logic [63:0]  fine8_in, fine8_ff;
   logic [16:0]  rnd9;
   logic [15:0]  phase9_ff;

   assign root_ext = {1'b0, up_root};
   assign mag1_in = (up_rem > {1'b0, root_ext}) ? (root_ext + {{W{1'b0}}, 1'b1}) : root_ext;
   assign mag_wide = EW'(mag1_ff);
   assign mag2_in = (mag_wide > EW'(17'h0FFFF)) ? r2p_pkg::MAG_MAX : mag_wide[15:0];

   assign p1_in = {32'b0, up_z[31:0]} * {32'b0, r2p_pkg::INV_PI_LO};
   assign p2_in = {32'b0, z1_ff[31:0]} * {32'b0, r2p_pkg::INV_PI_HI};
   assign p3_in = {32'b0, z2_ff[63:32]} * {32'b0, r2p_pkg::INV_PI_LO};
   assign p4_in = {32'b0, z3_ff[63:32]} * {32'b0, r2p_pkg::INV_PI_HI};
   assign acc3_in = acc2_ff + {32'b0, p2_ff, 32'b0};
   assign acc4_in = acc3_ff + {32'b0, p3_ff, 32'b0};
   assign acc5_in = acc4_ff + {p4_ff, 64'b0};

   // axis and diagonal angles are exact; mirror about the diagonal if swapped
   always_comb begin
      if (f5_ff.axis) begin
         base6 = '0;
      end else if (f5_ff.diag) begin
         base6 = r2p_pkg::TURN_EIGHTH;
      end else begin
         base6 = fine5_ff;
      end
      fine6_in = f5_ff.swap ? (r2p_pkg::TURN_QUARTER - base6) : base6;
   end

   assign fine7_in = f6_ff.rneg ? (r2p_pkg::TURN_HALF - fine6_ff) : fine6_ff;
   assign fine8_in = f7_ff.ineg ? (64'd0 - fine7_ff) : fine7_ff;

   // round half up at bit 47, wrap to 16 bits
   assign rnd9 = fine8_ff[62:46] + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[7:0], up_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ff <= up_flags;
         f2_ff <= f1_ff;
         f3_ff <= f2_ff;
         f4_ff <= f3_ff;
         f5_ff <= f4_ff;
         f6_ff <= f5_ff;
         f7_ff <= f6_ff;

         mag1_ff <= mag1_in;
         mag2_ff <= mag2_in;
         mag3_ff <= mag2_ff;
         mag4_ff <= mag3_ff;
         mag5_ff <= mag4_ff;
         mag6_ff <= mag5_ff;
         mag7_ff <= mag6_ff;
         mag8_ff <= mag7_ff;
         mag9_ff <= mag8_ff;

         z1_ff <= up_z;
         z2_ff <= z1_ff;
         z3_ff <= z2_ff;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
         acc2_ff <= {64'b0, p1_ff};
         acc3_ff <= acc3_in;
         acc4_ff <= acc4_in;
         fine5_ff <= acc5_in[127:64];

         fine6_ff <= fine6_in;
         fine7_ff <= fine7_in;
         fine8_ff <= fine8_in;
         phase9_ff <= rnd9[16:1];
      end
   end

   assign dn_valid = vld_ff[8];
   assign dn_magnitude = mag9_ff;
   assign dn_phase = phase9_ff;
endmodule
`default_nettype wire

// ===== hdl/rect_to_polar.sv =====
// Rectangular-to-polar converter. Each request carries one complex sample
// (signed real and imaginary parts of SAMPLE_BITS bits) and yields one
// response: the magnitude sqrt(re^2 + im^2) rounded to nearest (saturating
// at 65535 for wide samples) and the phase atan2(im, re) as a 16-bit binary
// angle with pi = 32768, rounded to nearest, +pi wrapping to -32768 and a
// zero sample giving phase 0. The datapath is a chain of 56 CORDIC cells,
// the first SAMPLE_BITS of them also carrying one digit of the square root,
// with three front stages
// (absolute value, squares and octant fold, start values) and nine back
// stages (multiply by 1/pi in four partial products, octant unfold,
// rounding). One request is taken per clock for as long as the response side
// keeps up; a two-entry output buffer lets the chain run on while one
// finished response waits.
`default_nettype none
module rect_to_polar #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_real_part,
   input  wire logic signed [SAMPLE_BITS-1:0] req_imag_part,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [15:0]                        rsp_magnitude,
   output logic signed [15:0]                 rsp_phase_angle
);
   localparam int W = SAMPLE_BITS;
   localparam int N = r2p_pkg::CORDIC_STEPS;

   logic advance;

   logic               c_valid [0:N];
   r2p_pkg::flags_type c_flags [0:N];
   logic [63:0]        c_x [0:N];
   logic [63:0]        c_y [0:N];
   logic [63:0]        c_z [0:N];
   logic [2*W-1:0]     c_sq [0:N];
   logic [W-1:0]       c_root [0:N];
   logic [W+1:0]       c_rem [0:N];

   logic        pipe_valid;
   logic [15:0] pipe_mag, pipe_phase;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   logic        out_take, out_load, out_from_skid, skid_load;
   logic [15:0] out_mag_ff, out_phase_ff, skid_mag_ff, skid_phase_ff;

   // the whole chain moves together; hold it only while the skid entry is full
   assign advance = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   r2p_front #(.SAMPLE_BITS(W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_valid (req_valid),
      .up_real  (req_real_part),
      .up_imag  (req_imag_part),
      .dn_valid (c_valid[0]),
      .dn_flags (c_flags[0]),
      .dn_x     (c_x[0]),
      .dn_y     (c_y[0]),
      .dn_sq    (c_sq[0])
   );

   assign c_z[0] = '0;
   assign c_root[0] = '0;
   assign c_rem[0] = '0;

   generate
      for (genvar i = 0; i < N; i++) begin : g_cell
         r2p_cell #(.SAMPLE_BITS(W), .STEP(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .up_valid (c_valid[i]),
            .up_flags (c_flags[i]),
            .up_x     (c_x[i]),
            .up_y     (c_y[i]),
            .up_z     (c_z[i]),
            .up_sq    (c_sq[i]),
            .up_root  (c_root[i]),
            .up_rem   (c_rem[i]),
            .dn_valid (c_valid[i+1]),
            .dn_flags (c_flags[i+1]),
            .dn_x     (c_x[i+1]),
            .dn_y     (c_y[i+1]),
            .dn_z     (c_z[i+1]),
            .dn_sq    (c_sq[i+1]),
            .dn_root  (c_root[i+1]),
            .dn_rem   (c_rem[i+1])
         );
      end
   endgenerate

   r2p_back #(.SAMPLE_BITS(W)) u_back (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .up_valid     (c_valid[N]),
      .up_flags     (c_flags[N]),
      .up_z         (c_z[N]),
      .up_root      (c_root[N]),
      .up_rem       (c_rem[N]),
      .dn_valid     (pipe_valid),
      .dn_magnitude (pipe_mag),
      .dn_phase     (pipe_phase)
   );

   // output register plus one skid entry
   assign out_take = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load = 1'b0;
      out_from_skid = 1'b0;
      skid_load = 1'b0;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_load = 1'b1;
            out_from_skid = 1'b1;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid) begin
         if (out_take) begin
            out_load = 1'b1;
            out_valid_in = 1'b1;
         end else begin
            skid_load = 1'b1;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_mag_ff <= out_from_skid ? skid_mag_ff : pipe_mag;
         out_phase_ff <= out_from_skid ? skid_phase_ff : pipe_phase;
      end
      if (skid_load) begin
         skid_mag_ff <= pipe_mag;
         skid_phase_ff <= pipe_phase;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_phase_angle = $signed(out_phase_ff);

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff && pipe_valid && out_valid_ff && rsp_stall |=> skid_valid_ff && out_valid_ff)
      else $error("finished request dropped while response stalled");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff && out_valid_ff)
      else $error("skid entry not moved to output register");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff && $stable(skid_mag_ff)
         && $stable(skid_phase_ff))
      else $error("skid entry lost while response stalled");
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
module tb;

   localparam int WIDTH = 16;
   localparam int ROTATIONS = 56;
   localparam int RANDOM_SAMPLES = 1100;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;

   localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;
   localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] EIGHTH_TURN = 64'h1000_0000_0000_0000;
   localparam logic [63:0] QUARTER_TURN = 64'h2000_0000_0000_0000;
   localparam logic [63:0] HALF_TURN = 64'h4000_0000_0000_0000;
   localparam logic [63:0] PHASE_HALF_LSB = 64'h0000_4000_0000_0000;

   typedef struct packed {
      logic [15:0]        magnitude;
      logic signed [15:0] phase;
   } polar_type;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               known;
      logic [15:0]        mag;
      logic signed [15:0] phase;
   } probe_type;

   typedef enum int {FLOW, LIGHT, HEAVY, BLOCKY} stall_mode_type;

   localparam int N_PROBES = 24;
   localparam probe_type PROBES [N_PROBES] = '{
      '{16'sd0,      16'sd0,      1'b1, 16'd0,     16'sd0},
      '{16'sd1,      16'sd0,      1'b1, 16'd1,     16'sd0},
      '{16'sd32767,  16'sd0,      1'b1, 16'd32767, 16'sd0},
      '{16'sh8000,   16'sd0,      1'b1, 16'd32768, 16'sh8000},
      '{16'sd0,      16'sd32767,  1'b1, 16'd32767, 16'sd16384},
      '{16'sd0,      16'sh8000,   1'b1, 16'd32768, -16'sd16384},
      '{-16'sd1,     16'sd0,      1'b1, 16'd1,     16'sh8000},
      '{16'sd0,      -16'sd1,     1'b1, 16'd1,     -16'sd16384},
      '{16'sd0,      16'sd1,      1'b1, 16'd1,     16'sd16384},
      '{16'sd1,      16'sd1,      1'b1, 16'd1,     16'sd8192},
      '{-16'sd1,     16'sd1,      1'b1, 16'd1,     16'sd24576},
      '{-16'sd1,     -16'sd1,     1'b1, 16'd1,     -16'sd24576},
      '{16'sd1,      -16'sd1,     1'b1, 16'd1,     -16'sd8192},
      '{16'sh8000,   16'sh8000,   1'b1, 16'd46341, -16'sd24576},
      '{16'sd32767,  16'sd32767,  1'b0, 16'd0,     16'sd0},
      '{16'sh8000,   16'sd32767,  1'b0, 16'd0,     16'sd0},
      '{16'sd32767,  16'sh8000,   1'b0, 16'd0,     16'sd0},
      '{16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
      '{16'sd32767,  16'sd1,      1'b0, 16'd0,     16'sd0},
      '{16'sd1,      16'sd32767,  1'b0, 16'd0,     16'sd0},
      '{16'sh8000,   -16'sd1,     1'b0, 16'd0,     16'sd0},
      '{16'sh8000,   16'sd1,      1'b0, 16'd0,     16'sd0},
      '{-16'sd2,     16'sd1,      1'b0, 16'd0,     16'sd0},
      '{16'sd12345,  -16'sd23456, 1'b0, 16'd0,     16'sd0}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [WIDTH-1:0] req_real_part;
   logic signed [WIDTH-1:0] req_imag_part;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [15:0]             rsp_magnitude;
   logic signed [15:0]      rsp_phase_angle;

   logic [63:0] arctan_q62 [ROTATIONS];
   probe_type   stimulus [$];
   polar_type   pending_polar [$];
   int          mismatches = 0;
   int          idle_cycles = 0;

   rect_to_polar #(.SAMPLE_BITS(WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_real_part(req_real_part),
      .req_imag_part(req_imag_part),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_magnitude(rsp_magnitude),
      .rsp_phase_angle(rsp_phase_angle)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // atan(2^-i) scaled by 2^62 from the truncated odd-power series
   function automatic void fill_arctan();
      logic [63:0] acc;
      logic [63:0] term;
      arctan_q62[0] = PI_Q60;
      for (int i = 1; i < ROTATIONS; i++) begin
         acc = '0;
         for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
            acc = (k % 2 == 0) ? acc + term : acc - term;
         end
         arctan_q62[i] = acc;
      end
   endfunction

   function automatic polar_type to_polar(input logic [15:0] re, input logic [15:0] im);
      logic [15:0]  ax;
      logic [15:0]  ay;
      logic [15:0]  hi;
      logic [15:0]  lo;
      logic [63:0]  sumsq;
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [63:0]  x;
      logic [63:0]  y;
      logic [63:0]  z;
      logic [63:0]  xs;
      logic [63:0]  ys;
      logic [63:0]  fine;
      logic [127:0] prod;
      logic         swap;
      polar_type    res;
      ax = re[15] ? 16'(16'd0 - re) : re;
      ay = im[15] ? 16'(16'd0 - im) : im;
      sumsq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sumsq) root = trial;
      end
      // round half up against the exact square
      if (sumsq - root * root > root) root = root + 64'd1;
      if (root > 64'hFFFF) root = 64'hFFFF;
      fine = '0;
      if (ax != 0 || ay != 0) begin
         swap = ay > ax;
         hi = swap ? ay : ax;
         lo = swap ? ax : ay;
         if (lo == 0) begin
            fine = '0;
         end else if (hi == lo) begin
            fine = EIGHTH_TURN;
         end else begin
            x = 64'(hi) << (56 - WIDTH);
            y = 64'(lo) << (56 - WIDTH);
            z = '0;
            for (int i = 0; i < ROTATIONS; i++) begin
               xs = x >> i;
               ys = $signed(y) >>> i;
               if (!y[63]) begin
                  x = x + ys;
                  y = y - xs;
                  z = z + arctan_q62[i];
               end else begin
                  x = x - ys;
                  y = y + xs;
                  z = z - arctan_q62[i];
               end
            end
            prod = {64'd0, z} * {64'd0, INV_PI_Q64};
            fine = prod[127:64];
         end
         // unfold the octant
         if (swap) fine = QUARTER_TURN - fine;
         if (re[15]) fine = HALF_TURN - fine;
         if (im[15]) fine = 64'd0 - fine;
      end
      res.magnitude = root[15:0];
      res.phase = 16'((fine + PHASE_HALF_LSB) >> 47);
      return res;
   endfunction

   function automatic probe_type random_probe();
      probe_type p;
      int        a;
      p = '0;
      p.re = 16'($urandom);
      p.im = 16'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            p.re = 16'(int'($urandom_range(0, 16)) - 8);
            p.im = 16'(int'($urandom_range(0, 16)) - 8);
         end
         5: begin
            if ($urandom_range(0, 1)) p.re = '0;
            else p.im = '0;
         end
         6: begin
            a = $urandom_range(1, 32768);
            p.re = 16'($urandom_range(0, 1) ? -a : a);
            p.im = 16'($urandom_range(0, 1) ? -a : a);
         end
         7: p.im = 16'(int'(p.re) + int'($urandom_range(0, 6)) - 3);
         8: begin
            case ($urandom_range(0, 5))
               0: p.re = 16'sh8000;
               1: p.re = -16'sd32767;
               2: p.re = -16'sd1;
               3: p.re = 16'sd0;
               4: p.re = 16'sd1;
               default: p.re = 16'sd32767;
            endcase
            case ($urandom_range(0, 5))
               0: p.im = 16'sh8000;
               1: p.im = -16'sd32767;
               2: p.im = -16'sd1;
               3: p.im = 16'sd0;
               4: p.im = 16'sd1;
               default: p.im = 16'sd32767;
            endcase
         end
         9: begin
            if ($urandom_range(0, 1)) p.re = 16'(int'($urandom_range(0, 8)) - 4);
            else p.im = 16'(int'($urandom_range(0, 8)) - 4);
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $time, what);
      mismatches++;
   endtask

   initial begin : drive_requests
      probe_type item;
      polar_type want;
      int        burst;
      int        gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_real_part = '0;
      req_imag_part = '0;
      fill_arctan();
      for (int n = 0; n < N_PROBES; n++) stimulus.push_back(PROBES[n]);
      repeat (RANDOM_SAMPLES) stimulus.push_back(random_probe());
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst = 0;
      foreach (stimulus[n]) begin
         item = stimulus[n];
         if (burst == 0) begin
            burst = $urandom_range(1, 60);
            case ($urandom_range(0, 7))
               0, 1: gap = 0;
               2: gap = $urandom_range(70, 90);
               default: gap = $urandom_range(1, 12);
            endcase
            if (gap != 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst--;
         @(negedge clock);
         req_valid <= 1'b1;
         req_real_part <= item.re;
         req_imag_part <= item.im;
         @(posedge clock);
         while (req_stall !== 1'b0) @(posedge clock);
         if (item.known) begin
            want.magnitude = item.mag;
            want.phase = item.phase;
         end else begin
            want = to_polar(item.re, item.im);
         end
         pending_polar.push_back(want);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_polar.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // response-side backpressure, independent of the sender
   initial begin : drive_stall
      stall_mode_type mode;
      int             span;
      rsp_stall = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               FLOW: rsp_stall <= 1'b0;
               LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
               HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
               default: rsp_stall <= ($urandom_range(0, 15) == 0) ? ~rsp_stall : rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      polar_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_polar.size() == 0) begin
            report_mismatch($sformatf("unexpected response mag=%0d phase=%0d",
                                      rsp_magnitude, rsp_phase_angle));
         end else begin
            want = pending_polar.pop_front();
            if (rsp_magnitude !== want.magnitude)
               report_mismatch($sformatf("magnitude got %0d want %0d",
                                         rsp_magnitude, want.magnitude));
            if (rsp_phase_angle !== want.phase)
               report_mismatch($sformatf("phase_angle got %0d want %0d",
                                         rsp_phase_angle, want.phase));
         end
      end
   end

   // count cycles without any request or response moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

endmodule
